// ===== rtl/core/clc_pkg.sv =====
// Shared types, constants and character codes for the comment/literal segmenter.
`timescale 1ns / 1ps
package clc_pkg;

    // Text position width; positions saturate at the top of this range.
    localparam int POS_BITS = 16;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    localparam int SEG_POS_W = 16;

    // Result queue depth; must hold two results from one byte plus one in flight.
    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_AW = $clog2(RESQ_DEPTH);

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SQUOTE  = 8'd39;
    localparam logic [7:0] CH_DQUOTE  = 8'd34;
    localparam logic [7:0] CH_SLASH   = 8'd47;
    localparam logic [7:0] CH_STAR    = 8'd42;
    localparam logic [7:0] CH_BSLASH  = 8'd92;

    typedef enum logic [1:0] {
        MODE_CODE  = 2'd0,
        MODE_LINE  = 2'd1,
        MODE_BLOCK = 2'd2
    } lex_mode_t;

    typedef enum logic [2:0] {
        CLS_CODE   = 3'd0,
        CLS_LINE   = 3'd1,
        CLS_BLOCK  = 3'd2,
        CLS_CHAR   = 3'd3,
        CLS_STRING = 3'd4
    } seg_class_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_item_t;

    typedef struct packed {
        logic [SEG_POS_W-1:0] seg_begin;
        logic [SEG_POS_W-1:0] seg_end;
        logic [2:0]           seg_class;
        logic                 last_segment;
    } seg_item_t;

    // Results produced by one lexer step: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        seg_item_t  res1;
        seg_item_t  res0;
    } step_out_t;

endpackage

// ===== rtl/core/clc_lexer.sv =====
// Lexer state and per-byte segment logic: up to two segments per byte.
`timescale 1ns / 1ps
module clc_lexer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  clc_pkg::text_item_t item,
    output clc_pkg::step_out_t  step_out
);
    import clc_pkg::*;

    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] seg_start_reg, seg_start_next;
    logic [POS_BITS-1:0] slash_at_reg, slash_at_next;
    lex_mode_t           mode_reg, mode_next;
    logic                dq_reg, dq_next;
    logic                sq_reg, sq_next;
    logic                esc_reg, esc_next;
    logic                slash_reg, slash_next;
    logic                star_reg, star_next;

    logic [POS_BITS-1:0] nxt;
    logic [7:0]          b;
    logic                eot;
    logic                handled;
    logic [1:0]          kind;
    logic                opened;
    logic [1:0]          n;
    seg_item_t           res_a [2];

    function automatic seg_item_t mk_res(input logic [POS_BITS-1:0] sb,
                                         input logic [POS_BITS-1:0] se,
                                         input seg_class_t cls);
        seg_item_t r;
        r.seg_begin    = SEG_POS_W'(sb);
        r.seg_end      = SEG_POS_W'(se);
        r.seg_class    = cls;
        r.last_segment = 1'b0;
        return r;
    endfunction

    always_comb begin
        b              = item.text_byte;
        eot            = item.end_of_text;
        nxt            = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        pos_next       = pos_reg;
        seg_start_next = seg_start_reg;
        slash_at_next  = slash_at_reg;
        mode_next      = mode_reg;
        dq_next        = dq_reg;
        sq_next        = sq_reg;
        esc_next       = esc_reg;
        slash_next     = slash_reg;
        star_next      = star_reg;
        handled        = 1'b0;
        kind           = 2'd0;
        opened         = 1'b0;
        n              = 2'd0;
        res_a[0]       = '0;
        res_a[1]       = '0;

        case (mode_reg)
            MODE_LINE: begin
                if (b == CH_NEWLINE || eot) begin
                    res_a[n[0]] = mk_res(seg_start_next, nxt, CLS_LINE);
                    n = n + 2'd1;
                    seg_start_next = nxt;
                    mode_next = MODE_CODE;
                end
            end
            MODE_BLOCK: begin
                if (star_reg && b == CH_SLASH) begin
                    res_a[n[0]] = mk_res(seg_start_next, nxt, CLS_BLOCK);
                    n = n + 2'd1;
                    seg_start_next = nxt;
                    mode_next = MODE_CODE;
                    star_next = 1'b0;
                end else begin
                    star_next = (b == CH_STAR);
                    if (eot) begin
                        res_a[n[0]] = mk_res(seg_start_next, nxt, CLS_BLOCK);
                        n = n + 2'd1;
                        seg_start_next = nxt;
                    end
                end
            end
            default: begin
                mode_next = MODE_CODE;
                if (slash_reg) begin
                    slash_next = 1'b0;
                    if (b == CH_SLASH || b == CH_STAR) begin
                        // held slash opens a comment; flush code before it
                        if (seg_start_next < slash_at_reg) begin
                            res_a[n[0]] = mk_res(seg_start_next, slash_at_reg, CLS_CODE);
                            n = n + 2'd1;
                        end
                        seg_start_next = slash_at_reg;
                        mode_next = (b == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                        star_next = 1'b0;
                        if (eot) begin
                            res_a[n[0]] = mk_res(seg_start_next, nxt,
                                (b == CH_SLASH) ? CLS_LINE : CLS_BLOCK);
                            n = n + 2'd1;
                            seg_start_next = nxt;
                        end
                        handled = 1'b1;
                    end
                end
                if (!handled) begin
                    if (!dq_reg && !sq_reg && b == CH_SLASH && !eot) begin
                        slash_next    = 1'b1;
                        slash_at_next = pos_reg;
                    end else begin
                        if (!esc_reg) begin
                            if (!sq_next && b == CH_DQUOTE) begin
                                dq_next = !dq_next;
                                kind    = 2'd2;
                                opened  = dq_next;
                            end
                            if (!dq_next && b == CH_SQUOTE) begin
                                sq_next = !sq_next;
                                kind    = 2'd1;
                                opened  = sq_next;
                            end
                            if (kind != 2'd0) begin
                                if (opened) begin
                                    if (seg_start_next < pos_reg) begin
                                        res_a[n[0]] = mk_res(seg_start_next, pos_reg,
                                                             CLS_CODE);
                                        n = n + 2'd1;
                                    end
                                    seg_start_next = pos_reg;
                                end else begin
                                    res_a[n[0]] = mk_res(seg_start_next, nxt,
                                        (kind == 2'd2) ? CLS_STRING : CLS_CHAR);
                                    n = n + 2'd1;
                                    seg_start_next = nxt;
                                end
                            end
                        end
                        // newline drops an open literal into the code segment
                        if (b == CH_NEWLINE) begin
                            dq_next = 1'b0;
                            sq_next = 1'b0;
                        end
                        esc_next = !esc_reg && (dq_next || sq_next) && b == CH_BSLASH;
                    end
                    if (eot && (seg_start_next < nxt || n == 2'd0)) begin
                        res_a[n[0]] = mk_res(seg_start_next, nxt, CLS_CODE);
                        n = n + 2'd1;
                        seg_start_next = nxt;
                    end
                end
            end
        endcase

        if (eot) begin
            if (n == 2'd0) begin
                res_a[0] = mk_res(seg_start_next, nxt, CLS_CODE);
                n = 2'd1;
            end
            if (n == 2'd1) begin
                res_a[0].last_segment = 1'b1;
            end else begin
                res_a[1].last_segment = 1'b1;
            end
            pos_next       = '0;
            seg_start_next = '0;
            slash_at_next  = '0;
            mode_next      = MODE_CODE;
            dq_next        = 1'b0;
            sq_next        = 1'b0;
            esc_next       = 1'b0;
            slash_next     = 1'b0;
            star_next      = 1'b0;
        end else begin
            pos_next = nxt;
        end

        step_out.count = n;
        step_out.res0  = res_a[0];
        step_out.res1  = res_a[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            seg_start_reg <= '0;
            slash_at_reg  <= '0;
            mode_reg      <= MODE_CODE;
            dq_reg        <= 1'b0;
            sq_reg        <= 1'b0;
            esc_reg       <= 1'b0;
            slash_reg     <= 1'b0;
            star_reg      <= 1'b0;
        end else if (step_en) begin
            pos_reg       <= pos_next;
            seg_start_reg <= seg_start_next;
            slash_at_reg  <= slash_at_next;
            mode_reg      <= mode_next;
            dq_reg        <= dq_next;
            sq_reg        <= sq_next;
            esc_reg       <= esc_next;
            slash_reg     <= slash_next;
            star_reg      <= star_next;
        end
    end

endmodule

// ===== rtl/core/clc_res_fifo.sv =====
// Result queue: takes up to two segments per cycle, hands out one per transaction.
`timescale 1ns / 1ps
module clc_res_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  clc_pkg::step_out_t wr_data,
    input  logic               wr_en,
    output logic               room2,
    output logic               m_valid,
    input  logic               m_ready,
    output clc_pkg::seg_item_t m_data
);
    import clc_pkg::*;

    seg_item_t             mem_reg [RESQ_DEPTH];
    logic [RESQ_AW-1:0]    head_reg, head_next;
    logic [RESQ_AW-1:0]    tail_reg, tail_next;
    logic [RESQ_AW:0]      cnt_reg, cnt_next;
    logic [1:0]            wr_cnt;
    logic                  rd;

    assign wr_cnt  = wr_en ? wr_data.count : 2'd0;
    assign m_valid = (cnt_reg != '0);
    assign rd      = m_valid && m_ready;
    assign room2   = (cnt_reg <= (RESQ_AW+1)'(RESQ_DEPTH - 2));
    assign m_data  = mem_reg[head_reg];

    always_comb begin
        head_next = rd ? head_reg + 1'b1 : head_reg;
        tail_next = tail_reg + RESQ_AW'(wr_cnt);
        cnt_next  = cnt_reg + (RESQ_AW+1)'(wr_cnt) - (RESQ_AW+1)'(rd);
    end

    always_ff @(posedge aclk) begin
        if (wr_cnt != 2'd0) begin
            mem_reg[tail_reg] <= wr_data.res0;
        end
        if (wr_cnt == 2'd2) begin
            mem_reg[tail_reg + 1'b1] <= wr_data.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/comment_literal_segmenter_core.sv =====
// Top level of the comment/literal segmenter: input register, lexer, result queue.
//
//  Channel  | Ports                      | Moves
//  ---------+----------------------------+----------------------------------------
//  input    | s_valid s_ready s_data     | one text byte and its end-of-text flag
//  result   | m_valid m_ready m_data     | one segment: begin, end, class, last
//
// A byte is held in the input register after its acceptance until the queue has room
// for two segments; it is then lexed and its segments are written into the queue.
// A byte yields zero, one or two segments; the queue drains one per cycle while
// m_ready is high, so a byte that yields two segments uses two output transfers.
// A new byte is taken while the input register is empty or is being lexed.
// Synchronous active-low reset returns the lexer to code mode at position zero.
`timescale 1ns / 1ps
module comment_literal_segmenter_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  clc_pkg::text_item_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output clc_pkg::seg_item_t  m_data
);
    import clc_pkg::*;

    text_item_t in_reg;
    logic       in_valid_reg, in_valid_next;
    logic       room2;
    logic       step_fire;
    logic       s_fire;
    step_out_t  step_out;

    assign step_fire = in_valid_reg && room2;
    assign s_ready   = !in_valid_reg || step_fire;
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (step_fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg <= s_data;
        end
    end

    clc_lexer u_lexer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (step_fire),
        .item     (in_reg),
        .step_out (step_out)
    );

    clc_res_fifo u_res_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_data (step_out),
        .wr_en   (step_fire),
        .room2   (room2),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // end of text always closes at least one segment
    a_eot_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire && in_reg.end_of_text |-> step_out.count != 2'd0)
        else $error("end of text produced no segment");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_fire |-> step_out.count != 2'd3)
        else $error("lexer step produced more than two segments");

    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.seg_class == CLS_CODE || m_data.seg_class == CLS_LINE ||
                     m_data.seg_class == CLS_BLOCK || m_data.seg_class == CLS_CHAR ||
                     m_data.seg_class == CLS_STRING))
        else $error("segment class out of range");

    // a held input byte is consumed once the queue has room
    a_step_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && room2 && !s_valid |=> !in_valid_reg)
        else $error("input register not drained");

endmodule

// ===== tb/comment_literal_segmenter_core_tb.sv =====
// Self-checking testbench for the comment/literal segmenter core.
`timescale 1ns / 1ps
module comment_literal_segmenter_core_tb;
    import clc_pkg::*;

    localparam int RANDOM_ITEMS    = 1350;
    localparam int LONG_TEXT_BYTES = 160;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int MAX_REPORTS     = 10;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    text_item_t s_data;
    logic       m_valid;
    logic       m_ready;
    seg_item_t  m_data;

    comment_literal_segmenter_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Lexer shadow state
    logic [POS_BITS-1:0] lx_pos;
    logic [POS_BITS-1:0] lx_start;
    logic [POS_BITS-1:0] lx_slash_at;
    lex_mode_t           lx_mode;
    bit                  lx_dq;
    bit                  lx_sq;
    bit                  lx_esc;
    bit                  lx_slash;
    bit                  lx_star;

    seg_item_t step_segs[2];
    int        step_n;
    seg_item_t pending_segs[$];
    logic [7:0] text_q[$];

    int mismatches;
    int idle_cycles;
    bit tx_active;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic lex_clear();
        lx_pos      = '0;
        lx_start    = '0;
        lx_slash_at = '0;
        lx_mode     = MODE_CODE;
        lx_dq       = 1'b0;
        lx_sq       = 1'b0;
        lx_esc      = 1'b0;
        lx_slash    = 1'b0;
        lx_star     = 1'b0;
    endtask

    function automatic void add_seg(input logic [POS_BITS-1:0] b, input logic [POS_BITS-1:0] e,
                                    input seg_class_t cls);
        step_segs[step_n] = '{seg_begin: SEG_POS_W'(b), seg_end: SEG_POS_W'(e),
                              seg_class: cls, last_segment: 1'b0};
        step_n++;
    endfunction

    // Advance the shadow lexer by one byte and queue the segments it closes.
    task automatic lex_byte(input logic [7:0] ch, input logic eot);
        logic [POS_BITS-1:0] cur;
        logic [POS_BITS-1:0] nxt;
        bit                  handled;
        bit                  opened;
        seg_class_t          qcls;
        cur     = lx_pos;
        nxt     = (cur == POS_MAX) ? cur : cur + 1'b1;
        step_n  = 0;
        handled = 1'b0;
        case (lx_mode)
            MODE_LINE: begin
                if (ch == CH_NEWLINE || eot) begin
                    add_seg(lx_start, nxt, CLS_LINE);
                    lx_start = nxt;
                    lx_mode  = MODE_CODE;
                end
            end
            MODE_BLOCK: begin
                if (lx_star && ch == CH_SLASH) begin
                    add_seg(lx_start, nxt, CLS_BLOCK);
                    lx_start = nxt;
                    lx_mode  = MODE_CODE;
                    lx_star  = 1'b0;
                end else begin
                    lx_star = (ch == CH_STAR);
                    if (eot) begin
                        add_seg(lx_start, nxt, CLS_BLOCK);
                        lx_start = nxt;
                    end
                end
            end
            default: begin
                lx_mode = MODE_CODE;
                if (lx_slash) begin
                    lx_slash = 1'b0;
                    if (ch == CH_SLASH || ch == CH_STAR) begin
                        if (lx_start < lx_slash_at)
                            add_seg(lx_start, lx_slash_at, CLS_CODE);
                        lx_start = lx_slash_at;
                        lx_mode  = (ch == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                        lx_star  = 1'b0;
                        if (eot) begin
                            add_seg(lx_start, nxt, (ch == CH_SLASH) ? CLS_LINE : CLS_BLOCK);
                            lx_start = nxt;
                        end
                        handled = 1'b1;
                    end
                end
                if (!handled) begin
                    if (!lx_dq && !lx_sq && ch == CH_SLASH && !eot) begin
                        lx_slash    = 1'b1;
                        lx_slash_at = cur;
                    end else begin
                        if (!lx_esc) begin
                            qcls   = CLS_CODE;
                            opened = 1'b0;
                            if (!lx_sq && ch == CH_DQUOTE) begin
                                lx_dq  = !lx_dq;
                                qcls   = CLS_STRING;
                                opened = lx_dq;
                            end
                            if (!lx_dq && ch == CH_SQUOTE) begin
                                lx_sq  = !lx_sq;
                                qcls   = CLS_CHAR;
                                opened = lx_sq;
                            end
                            if (qcls != CLS_CODE) begin
                                if (opened) begin
                                    if (lx_start < cur)
                                        add_seg(lx_start, cur, CLS_CODE);
                                    lx_start = cur;
                                end else begin
                                    add_seg(lx_start, nxt, qcls);
                                    lx_start = nxt;
                                end
                            end
                        end
                        // newline drops an open literal without closing its segment
                        if (ch == CH_NEWLINE) begin
                            lx_dq = 1'b0;
                            lx_sq = 1'b0;
                        end
                        lx_esc = !lx_esc && (lx_dq || lx_sq) && ch == CH_BSLASH;
                    end
                    if (eot && (lx_start < nxt || step_n == 0)) begin
                        add_seg(lx_start, nxt, CLS_CODE);
                        lx_start = nxt;
                    end
                end
            end
        endcase
        if (eot) begin
            if (step_n == 0)
                add_seg(lx_start, nxt, CLS_CODE);
            step_segs[step_n - 1].last_segment = 1'b1;
            lex_clear();
        end else begin
            lx_pos = nxt;
        end
        for (int i = 0; i < step_n; i++)
            pending_segs.insert(pending_segs.size(), step_segs[i]);
    endtask

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap(input bit gaps);
        int r;
        if (!gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic idle_input();
        if (tx_active) begin
            s_valid   <= 1'b0;
            tx_active = 1'b0;
        end
    endtask

    task automatic send_byte(input logic [7:0] ch, input logic eot, input bit gaps);
        int gap;
        gap = pick_gap(gaps);
        if (gap > 0) begin
            idle_input();
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_data    <= '{text_byte: ch, end_of_text: eot};
        tx_active = 1'b1;
        do @(posedge aclk); while (!s_ready);
        lex_byte(ch, eot);
    endtask

    task automatic send_text(input bit gaps);
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1, gaps);
    endtask

    task automatic add_byte(input logic [7:0] ch);
        text_q.insert(text_q.size(), ch);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    task automatic send_string(input string s);
        text_q.delete();
        push_str(s);
        send_text(1'b1);
    endtask

    // Hold the input off until every predicted segment has come out.
    task automatic wait_all_segments();
        idle_input();
        do @(posedge aclk); while (pending_segs.size() != 0);
    endtask

    function automatic logic [7:0] pick_char(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    task automatic add_lit_char();
        if ($urandom_range(0, 3) == 0) begin
            add_byte(CH_BSLASH);
            add_byte(pick_char("\"'\\n/"));
        end else begin
            add_byte(pick_char("ab /*'\"\\"));
        end
    endtask

    task automatic add_fragment();
        int kind;
        int len;
        kind = $urandom_range(0, 19);
        len  = $urandom_range(0, 5);
        if (kind < 4) begin
            repeat (len + 1) add_byte(pick_char("ab_x1 ;=(){}*+-\t\n"));
        end else if (kind < 7) begin
            push_str("//");
            repeat (len) add_byte(pick_char("ab *\"'/\\"));
            if ($urandom_range(0, 3) != 0)
                add_byte(CH_NEWLINE);
        end else if (kind < 10) begin
            push_str("/*");
            repeat (len) add_byte(pick_char("a*/\n\"'"));
            if ($urandom_range(0, 4) != 0)
                push_str("*/");
        end else if (kind < 13) begin
            add_byte(CH_DQUOTE);
            repeat (len) add_lit_char();
            add_byte(($urandom_range(0, 5) == 0) ? CH_NEWLINE : CH_DQUOTE);
        end else if (kind < 15) begin
            add_byte(CH_SQUOTE);
            add_lit_char();
            add_byte(($urandom_range(0, 5) == 0) ? CH_NEWLINE : CH_SQUOTE);
        end else if (kind < 17) begin
            add_byte(CH_SLASH);
            add_byte(pick_char("/*\"'a\n "));
        end else begin
            repeat (len % 3 + 1) add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_random_text();
        int cut;
        text_q.delete();
        repeat ($urandom_range(1, 8)) add_fragment();
        // sometimes end the text in the middle of a construct
        if ($urandom_range(0, 3) == 0 && text_q.size() > 1) begin
            cut = $urandom_range(1, text_q.size() - 1);
            repeat (cut) void'(text_q.pop_back());
        end
    endtask

    task automatic test_single_byte_texts();
        text_q = '{8'h00};
        send_text(1'b1);
        text_q = '{8'hFF};
        send_text(1'b1);
        send_string("/");
    endtask

    task automatic test_comment_forms();
        send_string("a//\n/*/*/");
        send_string("/*x");
    endtask

    task automatic test_literal_forms();
        send_string("'\\''\"\n");
        send_string("\"a\"//");
    endtask

    // Long text sent back to back, then drained completely.
    task automatic test_long_text();
        text_q.delete();
        repeat (LONG_TEXT_BYTES) add_byte(pick_char("abc xyz;\n"));
        push_str("a/*x*/'q'//y");
        send_text(1'b0);
        wait_all_segments();
    endtask

    task automatic test_random_texts();
        int sent;
        int texts;
        sent  = 0;
        texts = 0;
        while (sent < RANDOM_ITEMS) begin
            build_random_text();
            send_text($urandom_range(0, 3) != 0);
            sent += text_q.size();
            texts++;
            if (texts % 12 == 0)
                wait_all_segments();
        end
    endtask

    // Result side: random stalls, with occasional long stretches of ready
    initial begin : rx_pacing
        int run;
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
            m_ready <= 1'b0;
            repeat (stall) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : seg_check
        seg_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_segs.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected segment begin=%0d end=%0d class=%0d last=%0d",
                             $realtime, m_data.seg_begin, m_data.seg_end,
                             m_data.seg_class, m_data.last_segment);
            end else begin
                want = pending_segs.pop_front();
                if (m_data.seg_begin !== want.seg_begin || m_data.seg_end !== want.seg_end ||
                    m_data.seg_class !== want.seg_class ||
                    m_data.last_segment !== want.last_segment) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: segment mismatch exp b=%0d e=%0d c=%0d l=%0d",
                                  " got b=%0d e=%0d c=%0d l=%0d"},
                                 $realtime, want.seg_begin, want.seg_end, want.seg_class,
                                 want.last_segment, m_data.seg_begin, m_data.seg_end,
                                 m_data.seg_class, m_data.last_segment);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        mismatches  = 0;
        idle_cycles = 0;
        tx_active   = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        lex_clear();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_byte_texts();
        test_comment_forms();
        test_literal_forms();
        test_long_text();
        test_random_texts();

        wait_all_segments();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_segs.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
